// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the run merge RTL.
// Expects clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/kwrm_pkg.sv -----
// Types, codes and the entry ordering shared by the run merge modules.
// No dependencies.
package kwrm_pkg;

  localparam int KEY_BYTES = 4;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Flipping the sign bit of every key byte turns a signed-byte order into an
  // unsigned word order.
  localparam logic [8*KEY_BYTES-1:0] KEY_SIGN_FLIP = {KEY_BYTES{8'h80}};

  typedef struct packed {
    logic [31:0] name_key;
    logic [63:0] size;
    logic [31:0] position;
  } entry_t;

  // Scan token passed from cell to cell.
  typedef struct packed {
    logic   go;
    logic   found;
    entry_t ent;
  } tok_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } cell_stat_t;

  // True when a orders strictly before b.
  function automatic logic entry_less(entry_t a, entry_t b);
    logic [95:0] ka;
    logic [95:0] kb;
    ka = {a.name_key ^ KEY_SIGN_FLIP, a.size};
    kb = {b.name_key ^ KEY_SIGN_FLIP, b.size};
    return ka < kb;
  endfunction

endpackage

// ----- rtl/kwrm_cell.sv -----
// One run of the merge: its entry store, head and fill, and one scan stage.
// Depends on kwrm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module kwrm_cell #(
  parameter int RUN_DEPTH = 1024,
  parameter int IW        = 3,
  parameter int CELL_ID   = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load_en,
  input  kwrm_pkg::entry_t    load_entry,
  input  logic                pop_en,
  input  kwrm_pkg::tok_t      tok_in,
  input  logic [IW-1:0]       idx_in,
  output kwrm_pkg::tok_t      tok_out,
  output logic [IW-1:0]       idx_out,
  output kwrm_pkg::cell_stat_t stat
);
  import kwrm_pkg::*;

  localparam int AW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int CW = $clog2(RUN_DEPTH + 1);
  localparam logic [IW-1:0] MY_IDX = IW'(CELL_ID);

  entry_t        mem [RUN_DEPTH];
  entry_t        rd_q;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          nonempty;
  logic          take;
  logic          go_r;
  logic          found_r;
  entry_t        ent_r;
  logic [IW-1:0] idx_r;

  assign nonempty = head_r < fill_r;
  assign stat.full = fill_r >= CW'(RUN_DEPTH);
  assign stat.nonempty = nonempty;

  // Append at the tail, read the head every cycle.
  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[fill_r[AW-1:0]] <= load_entry;
    end
    rd_q <= mem[head_r[AW-1:0]];
  end

  // Advance head on a pop; an exhausted run drops back to empty.
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (load_en) begin
      fill_nxt = fill_r + CW'(1);
    end else if (pop_en) begin
      if (head_r + CW'(1) >= fill_r) begin
        head_nxt = '0;
        fill_nxt = '0;
      end else begin
        head_nxt = head_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Replace the running best only on a strict win so lower runs keep ties.
  assign take = tok_in.go && nonempty && (!tok_in.found || entry_less(rd_q, tok_in.ent));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r <= 1'b0;
    end else begin
      go_r <= tok_in.go;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found_r <= 1'b1;
      ent_r   <= rd_q;
      idx_r   <= MY_IDX;
    end else begin
      found_r <= tok_in.found;
      ent_r   <= tok_in.ent;
      idx_r   <= idx_in;
    end
  end

  assign tok_out.go    = go_r;
  assign tok_out.found = found_r;
  assign tok_out.ent   = ent_r;
  assign idx_out       = idx_r;

  `ASSERT_AT(a_head_in_fill, head_r <= fill_r, "run head passed its fill")
  `ASSERT_NEVER(a_load_full, load_en && stat.full, "load written into a full run")
  `ASSERT_NEVER(a_pop_empty, pop_en && !nonempty, "pop from an empty run")

endmodule

// ----- rtl/k_way_run_merge.sv -----
// K-way run merge: loads append entries to per-run stores; a pop returns the least head.
// A pop result is registered once the scan token has walked the row of RUNS run cells,
// one cell per cycle, and then waits in the done state until the output is free; one
// item is in flight at a time, so no new transaction is taken until a pop or an
// overflowing load has handed its result to the output register; a load that fits
// gives no result. Reset (synchronous, rst_n low) empties every run at once.
`include "assert_macros.svh"
module k_way_run_merge #(
  parameter int RUNS      = 8,
  parameter int RUN_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [2:0]  in_run_index,
  input  logic [31:0] in_name_key,
  input  logic [63:0] in_entry_size,
  input  logic [31:0] in_entry_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_position,
  output logic [31:0] out_name_key,
  output logic [63:0] out_size,
  output logic        out_all_empty,
  output logic        out_load_overflow
);
  import kwrm_pkg::*;

  localparam int IW = (RUNS > 1) ? $clog2(RUNS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]   state_r, state_nxt;
  logic         in_fire;
  logic         out_free;
  logic         go0_r;
  tok_t         tok   [RUNS+1];
  logic [IW-1:0] idx  [RUNS+1];
  cell_stat_t   stat  [RUNS];
  logic [RUNS-1:0] hit;
  logic [RUNS-1:0] fullv;
  logic [RUNS-1:0] load_en;
  logic [RUNS-1:0] pop_en;
  logic         bad_run;
  logic         load_bad;
  logic         scan_done;
  entry_t       load_entry;
  entry_t       res_ent_r;
  logic         res_empty_r;
  logic         res_ovf_r;
  logic         out_valid_r;
  entry_t       out_ent_r;
  logic         out_empty_r;
  logic         out_ovf_r;

  assign in_ready  = state_r == ST_IDLE;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_done = (state_r == ST_SCAN) && tok[RUNS].go;

  assign load_entry.name_key = in_name_key;
  assign load_entry.size     = in_entry_size;
  assign load_entry.position = in_entry_position;

  // Decode the target run and its full flag, and the run that a finished scan pops.
  always_comb begin
    for (int i = 0; i < RUNS; i++) begin
      hit[i]     = 32'(in_run_index) == 32'(i);
      fullv[i]   = stat[i].full;
      load_en[i] = in_fire && (in_operation == OP_LOAD) && hit[i] && !fullv[i];
      pop_en[i]  = scan_done && tok[RUNS].found && (idx[RUNS] == IW'(i));
    end
  end

  assign bad_run  = 32'(in_run_index) >= 32'(RUNS);
  assign load_bad = bad_run || (|(hit & fullv));

  // Seed the scan chain with an empty token.
  assign tok[0].go    = go0_r;
  assign tok[0].found = 1'b0;
  assign tok[0].ent   = '0;
  assign idx[0]       = '0;

  for (genvar g = 0; g < RUNS; g++) begin : g_cell
    kwrm_cell #(
      .RUN_DEPTH (RUN_DEPTH),
      .IW        (IW),
      .CELL_ID   (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .load_en    (load_en[g]),
      .load_entry (load_entry),
      .pop_en     (pop_en[g]),
      .tok_in     (tok[g]),
      .idx_in     (idx[g]),
      .tok_out    (tok[g+1]),
      .idx_out    (idx[g+1]),
      .stat       (stat[g])
    );
  end

  // Sequence one transaction at a time.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_POP) begin
            state_nxt = ST_SCAN;
          end else if (load_bad) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (tok[RUNS].go) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go0_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go0_r   <= in_fire && (in_operation == OP_POP);
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the pending result.
  always_ff @(posedge clk) begin
    if (in_fire && in_operation == OP_LOAD) begin
      res_ent_r   <= '0;
      res_empty_r <= 1'b0;
      res_ovf_r   <= 1'b1;
    end else if (scan_done) begin
      res_ent_r   <= tok[RUNS].found ? tok[RUNS].ent : '0;
      res_empty_r <= !tok[RUNS].found;
      res_ovf_r   <= 1'b0;
    end
  end

  // Hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_ent_r   <= res_ent_r;
      out_empty_r <= res_empty_r;
      out_ovf_r   <= res_ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_position      = out_ent_r.position;
  assign out_name_key      = out_ent_r.name_key;
  assign out_size          = out_ent_r.size;
  assign out_all_empty     = out_empty_r;
  assign out_load_overflow = out_ovf_r;

  `ASSERT_AT(a_pop_onehot, $onehot0(pop_en), "more than one run advanced")
  `ASSERT_NEVER(a_load_pop, (|load_en) && (|pop_en), "load and pop in one cycle")
  `ASSERT_AT(a_tok_in_scan, tok[RUNS].go |-> state_r == ST_SCAN, "scan token outside a scan")
  `ASSERT_AT(a_pop_seeds, (in_fire && in_operation == OP_POP) |=> go0_r, "pop did not start a scan")

endmodule

// ----- test/tb_k_way_run_merge.sv -----
// Self-checking testbench for k_way_run_merge: loads sorted runs, pops the merged
// stream and checks every result against an in-bench merge predictor.
// Depends on kwrm_pkg (entry_t, operation codes, key sign flip) and the RTL top.
module tb_k_way_run_merge;
  import kwrm_pkg::*;

  localparam int RUNS        = 8;
  localparam int RUN_DEPTH   = 1024;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = RUNS + 8;
  localparam int RANDOM_MIX  = 800;

  typedef struct {
    logic       op;
    logic [2:0] run;
    entry_t     ent;
    bit         hold;
  } req_t;

  typedef struct packed {
    logic [31:0] position;
    logic [31:0] name_key;
    logic [63:0] size;
    logic        all_empty;
    logic        overflow;
  } merge_res_t;

  logic        clk;
  logic        rst_n             = 1'b0;
  logic        in_valid          = 1'b0;
  logic        in_ready;
  logic        in_operation      = OP_LOAD;
  logic [2:0]  in_run_index      = '0;
  logic [31:0] in_name_key       = '0;
  logic [63:0] in_entry_size     = '0;
  logic [31:0] in_entry_position = '0;
  logic        out_valid;
  logic        out_ready         = 1'b0;
  logic [31:0] out_position;
  logic [31:0] out_name_key;
  logic [63:0] out_size;
  logic        out_all_empty;
  logic        out_load_overflow;

  k_way_run_merge #(
    .RUNS      (RUNS),
    .RUN_DEPTH (RUN_DEPTH)
  ) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_run_index      (in_run_index),
    .in_name_key       (in_name_key),
    .in_entry_size     (in_entry_size),
    .in_entry_position (in_entry_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_position      (out_position),
    .out_name_key      (out_name_key),
    .out_size          (out_size),
    .out_all_empty     (out_all_empty),
    .out_load_overflow (out_load_overflow)
  );

  // Stimulus and expected results
  req_t       stim_q[$];
  merge_res_t merge_expect[$];
  int         sent_cnt        = 0;
  int         errors          = 0;
  int         pending_entries = 0;
  int         quiet_cycles    = 0;
  logic       in_fired        = 1'b0;
  logic       out_fired       = 1'b0;

  // Shadow copy of the run stores
  entry_t shadow_mem [RUNS][RUN_DEPTH];
  int     shadow_head [RUNS] = '{default: 0};
  int     shadow_fill [RUNS] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Merge order: name bytes as signed bytes, first byte first, then size unsigned.
  function automatic bit orders_first(entry_t a, entry_t b);
    logic signed [7:0] ba;
    logic signed [7:0] bb;
    int i;
    for (i = 0; i < KEY_BYTES; i++) begin
      ba = a.name_key[31-8*i -: 8];
      bb = b.name_key[31-8*i -: 8];
      if (ba != bb) return ba < bb;
    end
    return a.size < b.size;
  endfunction

  // Apply one accepted transaction to the shadow stores and queue its result.
  task automatic predict_merge(logic op, logic [2:0] run, entry_t ent);
    merge_res_t res;
    entry_t     pick;
    int         best;
    int         k;
    res = '0;
    if (op == OP_LOAD) begin
      if (int'(run) >= RUNS || shadow_fill[run] >= RUN_DEPTH) begin
        res.overflow = 1'b1;
        merge_expect.push_back(res);
      end else begin
        shadow_mem[run][shadow_fill[run]] = ent;
        shadow_fill[run]++;
      end
    end else begin
      best = -1;
      pick = '0;
      for (k = 0; k < RUNS; k++) begin
        if (shadow_head[k] < shadow_fill[k]) begin
          if (best < 0 || orders_first(shadow_mem[k][shadow_head[k]], pick)) begin
            pick = shadow_mem[k][shadow_head[k]];
            best = k;
          end
        end
      end
      if (best < 0) begin
        res.all_empty = 1'b1;
      end else begin
        res.position = pick.position;
        res.name_key = pick.name_key;
        res.size     = pick.size;
        shadow_head[best]++;
        // Drop an exhausted run and free it for new loads
        if (shadow_head[best] >= shadow_fill[best]) begin
          shadow_head[best] = 0;
          shadow_fill[best] = 0;
        end
      end
      merge_expect.push_back(res);
    end
  endtask

  task automatic check_field(string fld, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
    end
  endtask

  // Stimulus helpers
  function automatic entry_t mk_entry(logic [31:0] key, logic [63:0] size, logic [31:0] pos);
    entry_t e;
    e.name_key = key;
    e.size     = size;
    e.position = pos;
    return e;
  endfunction

  function automatic entry_t any_entry();
    return mk_entry($urandom, {$urandom, $urandom}, $urandom);
  endfunction

  // Bias key bytes toward sign boundaries; narrow keeps the alphabet tiny for ties.
  function automatic logic [7:0] pick_byte(bit narrow);
    case ($urandom_range(0, narrow ? 3 : 7))
      0:       return 8'h00;
      1:       return 8'h80;
      2:       return 8'hff;
      3:       return 8'h7f;
      4:       return 8'h01;
      5:       return 8'hfe;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_size(bit narrow);
    if (narrow) return 64'($urandom_range(0, 2));
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 64'h8000_0000_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_req(logic op, logic [2:0] run, entry_t ent, bit hold);
    req_t q;
    q.op   = op;
    q.run  = run;
    q.ent  = ent;
    q.hold = hold;
    stim_q.push_back(q);
  endtask

  task automatic push_pop(bit hold);
    push_req(OP_POP, 3'($urandom), any_entry(), hold);
    if (pending_entries > 0) pending_entries--;
  endtask

  // Load sorted runs into several stores, interleaved with stray loads and pops, then merge them all out.
  task automatic queue_episode(bit hold);
    entry_t lists [RUNS][$];
    entry_t e;
    bit     narrow;
    bit     first;
    int     r;
    int     n;
    int     i;
    int     j;
    int     left;
    narrow = ($urandom_range(0, 2) == 0);
    first  = hold;
    left   = 0;
    for (r = 0; r < RUNS; r++) begin
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      for (i = 0; i < n; i++) begin
        e = mk_entry({pick_byte(narrow), pick_byte(narrow), pick_byte(narrow),
                      pick_byte(narrow)}, pick_size(narrow), $urandom);
        j = 0;
        while (j < lists[r].size() && !orders_first(e, lists[r][j])) j++;
        lists[r].insert(j, e);
      end
      left += n;
    end
    while (left > 0) begin
      if ($urandom_range(0, 7) == 0) begin
        push_pop(first);
      end else if ($urandom_range(0, 11) == 0) begin
        push_req(OP_LOAD, 3'($urandom), any_entry(), first);
        pending_entries++;
      end else begin
        r = $urandom_range(0, RUNS - 1);
        while (lists[r].size() == 0) r = (r + 1) % RUNS;
        push_req(OP_LOAD, 3'(r), lists[r].pop_front(), first);
        pending_entries++;
        left--;
      end
      first = 1'b0;
    end
    // Drain everything, plus one pop that finds every run empty
    n = pending_entries + 1;
    for (i = 0; i < n; i++) push_pop(first && i == 0);
  endtask

  task automatic queue_noise(int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        push_pop(1'b0);
      end else begin
        push_req(OP_LOAD, 3'($urandom), any_entry(), 1'b0);
        pending_entries++;
      end
    end
  endtask

  // Fill one run to its depth in ascending order, then hit it with loads that overflow.
  task automatic queue_full_run();
    entry_t      e;
    logic [31:0] v;
    int          r;
    int          i;
    int          step;
    r = $urandom_range(0, RUNS - 1);
    v = $urandom_range(0, 32'h7fff_0000);
    e = '0;
    for (i = 0; i < RUN_DEPTH; i++) begin
      step       = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
      v          = v + step;
      e.size     = (step == 0) ? e.size + $urandom_range(0, 2) : {$urandom, $urandom};
      e.name_key = v ^ KEY_SIGN_FLIP;
      e.position = $urandom;
      push_req(OP_LOAD, 3'(r), e, i == 0);
    end
    for (i = 0; i < 4; i++) begin
      push_req(OP_LOAD, 3'(r), any_entry(), 1'b0);
      push_req(OP_LOAD, 3'((r + 1) % RUNS), any_entry(), 1'b0);
      push_req(OP_POP, 3'($urandom), any_entry(), 1'b0);
    end
    repeat (20) push_req(OP_POP, 3'($urandom), any_entry(), 1'b0);
  endtask

  // Build the stimulus, run reset, wait for the last result and report
  initial begin : main
    int total;
    int ep;

    // Pop on empty, byte sign boundaries, full tie on low index, run exhaustion
    push_req(OP_POP,  3'd0, mk_entry('0, '0, '0), 1'b0);
    push_req(OP_LOAD, 3'd0, mk_entry(32'h8000_0000, '1, 32'hffff_ffff), 1'b0);
    push_req(OP_LOAD, 3'd0, mk_entry(32'h8000_0000, '1, 32'h0000_0001), 1'b0);
    push_req(OP_LOAD, 3'd1, mk_entry(32'h7fff_ffff, 64'd0, 32'h11), 1'b0);
    push_req(OP_LOAD, 3'd2, mk_entry(32'h0000_0000, 64'd5, 32'h22), 1'b0);
    push_req(OP_LOAD, 3'd3, mk_entry(32'h0000_0000, 64'd5, 32'h33), 1'b0);
    push_req(OP_LOAD, 3'd4, mk_entry(32'h0080_0000, 64'd9, 32'h44), 1'b0);
    push_req(OP_LOAD, 3'd5, mk_entry(32'h0000_00ff, 64'd0, 32'h55), 1'b0);
    push_req(OP_LOAD, 3'd6, mk_entry(32'hffff_ffff, 64'd0, 32'h66), 1'b0);
    push_req(OP_LOAD, 3'd7, mk_entry(32'h0000_0000, 64'd4, 32'h77), 1'b0);
    repeat (10) push_req(OP_POP, 3'd7, mk_entry('1, '1, '1), 1'b0);
    push_req(OP_LOAD, 3'd7, mk_entry(32'h0102_0304, 64'd1, 32'h88), 1'b0);
    push_req(OP_POP,  3'd0, mk_entry('0, '0, '0), 1'b0);
    push_req(OP_POP,  3'd0, mk_entry('0, '0, '0), 1'b0);

    ep = 0;
    while (stim_q.size() < RANDOM_MIX) begin
      queue_episode(ep % 4 == 0);
      if ($urandom_range(0, 2) == 0) queue_noise($urandom_range(1, 8));
      ep++;
    end
    while (pending_entries > 0) push_pop(1'b0);
    queue_full_run();
    total = stim_q.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (sent_cnt < total || merge_expect.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && merge_expect.size() == 0) begin
      $display("tb_k_way_run_merge passed");
    end else begin
      $display("tb_k_way_run_merge failed");
    end
    $finish;
  end

  // Driver: present the next transaction after a random gap, hold it until taken
  int send_gap  = 0;
  bit send_calm = 1'b0;
  always @(negedge clk) begin : driver
    req_t nxt;
    logic drive;
    if (rst_n) begin
      drive = in_valid && !in_fired;
      if (in_valid && in_fired) begin
        sent_cnt++;
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : $urandom_range(0, 19);
      end
      if (!drive) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_q.size() > 0 && !(stim_q[0].hold && merge_expect.size() != 0)) begin
          nxt               = stim_q.pop_front();
          drive             = 1'b1;
          in_operation      <= nxt.op;
          in_run_index      <= nxt.run;
          in_name_key       <= nxt.ent.name_key;
          in_entry_size     <= nxt.ent.size;
          in_entry_position <= nxt.ent.position;
        end
      end
      in_valid <= drive;
    end
  end

  // Receiver: stall a random number of cycles after each result
  int recv_wait = 0;
  bit recv_calm = 1'b0;
  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (out_fired) begin
        if ($urandom_range(0, 49) == 0) recv_calm = !recv_calm;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 19);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each input transaction, check each result transaction
  always @(posedge clk) begin : monitor
    merge_res_t want;
    if (!rst_n) begin
      in_fired  <= 1'b0;
      out_fired <= 1'b0;
    end else begin
      in_fired  <= in_valid && in_ready;
      out_fired <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        predict_merge(in_operation, in_run_index,
                      mk_entry(in_name_key, in_entry_size, in_entry_position));
      end
      if (out_valid && out_ready) begin
        if (merge_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got pos %h key %h size %h e %b o %b",
                   $time, out_position, out_name_key, out_size, out_all_empty,
                   out_load_overflow);
        end else begin
          want = merge_expect.pop_front();
          check_field("out_position", 64'(want.position), 64'(out_position));
          check_field("out_name_key", 64'(want.name_key), 64'(out_name_key));
          check_field("out_size", want.size, out_size);
          check_field("out_all_empty", 64'(want.all_empty), 64'(out_all_empty));
          check_field("out_load_overflow", 64'(want.overflow), 64'(out_load_overflow));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_k_way_run_merge failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/kwrm_pkg.sv
rtl/kwrm_cell.sv
rtl/k_way_run_merge.sv
test/tb_k_way_run_merge.sv
